// ----- rtl/core/sqsc_pkg.sv -----
// Shared types, register indexes and helpers for the sprite quad setup block.
// Used by the axis placement unit, the top level and the port checker.
package sqsc_pkg;

  localparam int FRAC_BITS_DEF = 4;

  // Edge arithmetic width; holds every exact edge for any fraction width up to 8.
  localparam int EDGE_W = 20;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SHAKE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHAKE_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_ENABLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_COLOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_TOP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd7;

  localparam logic [11:0] VIEW_WIDTH_RST  = 12'd640;
  localparam logic [11:0] VIEW_HEIGHT_RST = 12'd480;

  localparam logic [1:0] ANCHOR_CENTER     = 2'd0;
  localparam logic [1:0] ANCHOR_START      = 2'd1;
  localparam logic [1:0] ANCHOR_END        = 2'd2;
  localparam logic [1:0] ANCHOR_CENTER_ALT = 2'd3;

  localparam logic signed [EDGE_W-1:0] SAT_HI = EDGE_W'(32767);
  localparam logic signed [EDGE_W-1:0] SAT_LO = -EDGE_W'(32768);

  typedef struct packed {
    logic               snap;
    logic [1:0]         anchor_x;
    logic [1:0]         anchor_y;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        size_w;
    logic [15:0]        size_h;
    logic [31:0]        base_color;
  } sprite_t;

  typedef struct packed {
    logic signed [15:0] edge_left;
    logic signed [15:0] edge_right;
    logic signed [15:0] edge_top;
    logic signed [15:0] edge_bottom;
    logic [31:0]        vertex_color;
    logic               culled;
  } quad_t;

  typedef struct packed {
    logic       snap;
    logic [1:0] anchor;
  } axis_ctl_t;

  function automatic logic signed [15:0] sat16(input logic signed [EDGE_W-1:0] v);
    logic signed [15:0] r;
    if (v > SAT_HI) begin
      r = 16'sh7FFF;
    end else if (v < SAT_LO) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/sprite_quad_setup_cull.sv -----
// Top level of the sprite quad setup and viewport cull block.
// Depends on sqsc_pkg and sqsc_axis.
//
// Usage:
//   Sprite items arrive on sprite and are taken at a clock edge where start is
//   high and busy is low. busy is high while reset is applied and in the first
//   cycle after it, so one item can be taken in every cycle after that.
//   Each item yields one quad on the quad port, marked by done for exactly one
//   cycle, after passing the input register and then the result register.
//   Throughput is one item per clock; the path between the two registers is
//   the edge adders, the viewport compares and four 8x8 colour multipliers.
//   The receiver cannot stall: a quad is shown for one cycle only.
//   Configuration registers are written on cfg_valid/cfg_ready with cfg_index
//   and cfg_data; they are meant to change only while no item is in flight.
//   Reset clears the pipeline valid flags and loads the register defaults
//   (viewport 640 by 480 at the origin, no shake, no colour mix).
module sprite_quad_setup_cull #(
  parameter int FRAC_BITS = sqsc_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  sqsc_pkg::sprite_t                  sprite,
  output logic                               done,
  output sqsc_pkg::quad_t                    quad,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sqsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                        cfg_data
);
  import sqsc_pkg::*;

  // Compare width covers the exact edges and the scaled viewport bounds.
  localparam int CW = (EDGE_W > 13 + FRAC_BITS) ? EDGE_W + 1 : 14 + FRAC_BITS;

  logic signed [12:0] shake_x;
  logic signed [12:0] shake_y;
  logic               mix_enable;
  logic [31:0]        mix_color;
  logic [11:0]        view_left;
  logic [11:0]        view_top;
  logic [11:0]        view_width;
  logic [11:0]        view_height;

  logic      s1_valid;
  sprite_t   s1_item;
  axis_ctl_t ctl_x;
  axis_ctl_t ctl_y;

  logic signed [EDGE_W-1:0] l_e;
  logic signed [EDGE_W-1:0] r_e;
  logic signed [EDGE_W-1:0] t_e;
  logic signed [EDGE_W-1:0] b_e;

  logic signed [CW-1:0] vl;
  logic signed [CW-1:0] vt;
  logic signed [CW-1:0] vr;
  logic signed [CW-1:0] vb;
  logic                 cull;
  logic [31:0]          mixed;
  logic [31:0]          color;
  quad_t                quad_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign cfg_ready = ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      shake_x     <= '0;
      shake_y     <= '0;
      mix_enable  <= 1'b0;
      mix_color   <= '0;
      view_left   <= '0;
      view_top    <= '0;
      view_width  <= VIEW_WIDTH_RST;
      view_height <= VIEW_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SHAKE_X:     shake_x     <= cfg_data[12:0];
        REG_SHAKE_Y:     shake_y     <= cfg_data[12:0];
        REG_MIX_ENABLE:  mix_enable  <= cfg_data[0];
        REG_MIX_COLOR:   mix_color   <= cfg_data;
        REG_VIEW_LEFT:   view_left   <= cfg_data[11:0];
        REG_VIEW_TOP:    view_top    <= cfg_data[11:0];
        REG_VIEW_WIDTH:  view_width  <= cfg_data[11:0];
        REG_VIEW_HEIGHT: view_height <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_item <= sprite;
    end
  end

  assign ctl_x = '{snap: s1_item.snap, anchor: s1_item.anchor_x};
  assign ctl_y = '{snap: s1_item.snap, anchor: s1_item.anchor_y};

  sqsc_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .ctl   (ctl_x),
    .pos   (s1_item.pos_x),
    .size  (s1_item.size_w),
    .shake (shake_x),
    .lo    (l_e),
    .hi    (r_e)
  );

  sqsc_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .ctl   (ctl_y),
    .pos   (s1_item.pos_y),
    .size  (s1_item.size_h),
    .shake (shake_y),
    .lo    (t_e),
    .hi    (b_e)
  );

  assign vl = signed'(CW'(view_left) << FRAC_BITS);
  assign vt = signed'(CW'(view_top) << FRAC_BITS);
  assign vr = signed'((CW'(view_left) + CW'(view_width)) << FRAC_BITS);
  assign vb = signed'((CW'(view_top) + CW'(view_height)) << FRAC_BITS);

  assign cull = (CW'(r_e) < vl) || (CW'(b_e) < vt) ||
                (CW'(l_e) > vr) || (CW'(t_e) > vb);

  // Per-channel colour mix: (c * m) >> 7, capped at full scale.
  always_comb begin
    logic [15:0] prod;
    mixed = '0;
    for (int ch = 0; ch < 4; ch++) begin
      prod = 16'(s1_item.base_color[ch*8 +: 8]) * 16'(mix_color[ch*8 +: 8]);
      mixed[ch*8 +: 8] = prod[15] ? 8'hFF : prod[14:7];
    end
  end

  assign color = mix_enable ? mixed : s1_item.base_color;

  always_comb begin
    quad_next.edge_left    = sat16(l_e);
    quad_next.edge_right   = sat16(r_e);
    quad_next.edge_top     = sat16(t_e);
    quad_next.edge_bottom  = sat16(b_e);
    quad_next.vertex_color = cull ? 32'd0 : color;
    quad_next.culled       = cull;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      quad <= quad_next;
    end
  end

endmodule

// ----- rtl/core/sqsc_axis.sv -----
// Places one axis of a sprite quad: anchor, shake offset and pixel snapping.
// Pure combinational; depends on sqsc_pkg.
module sqsc_axis #(
  parameter int FRAC_BITS = sqsc_pkg::FRAC_BITS_DEF
) (
  input  sqsc_pkg::axis_ctl_t                   ctl,
  input  logic signed [15:0]                    pos,
  input  logic [15:0]                           size,
  input  logic signed [12:0]                    shake,
  output logic signed [sqsc_pkg::EDGE_W-1:0]    lo,
  output logic signed [sqsc_pkg::EDGE_W-1:0]    hi
);
  import sqsc_pkg::*;

  localparam logic [FRAC_BITS-1:0] HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

  logic signed [EDGE_W-1:0] p;
  logic signed [EDGE_W-1:0] s;
  logic signed [EDGE_W-1:0] sh;
  logic signed [EDGE_W-1:0] twice;
  logic signed [EDGE_W-1:0] start_pt;
  logic signed [EDGE_W-1:0] lo_raw;
  logic signed [EDGE_W-1:0] hi_raw;

  // Round to the nearest whole pixel, ties to the even pixel, then drop half a pixel.
  function automatic logic signed [EDGE_W-1:0] snap_edge(input logic signed [EDGE_W-1:0] v);
    logic signed [EDGE_W-1:0] whole;
    logic [FRAC_BITS-1:0]     frac;
    logic                     up;
    whole = v >>> FRAC_BITS;
    frac  = v[FRAC_BITS-1:0];
    up    = (frac > HALF) || ((frac == HALF) && whole[0]);
    return ((whole + EDGE_W'(up)) <<< FRAC_BITS) - EDGE_W'(HALF);
  endfunction

  assign p     = EDGE_W'(pos);
  assign s     = signed'(EDGE_W'(size));
  assign sh    = EDGE_W'(shake);
  assign twice = (p <<< 1) - s;

  always_comb begin
    unique case (ctl.anchor)
      ANCHOR_START: start_pt = p;
      ANCHOR_END:   start_pt = p - s;
      ANCHOR_CENTER, ANCHOR_CENTER_ALT: begin
        if (ctl.snap) begin
          start_pt = (twice >>> (FRAC_BITS + 1)) <<< FRAC_BITS;
        end else begin
          start_pt = twice >>> 1;
        end
      end
      default: start_pt = p;
    endcase
  end

  assign lo_raw = start_pt + sh;
  assign hi_raw = start_pt + s + sh;
  assign lo     = ctl.snap ? snap_edge(lo_raw) : lo_raw;
  assign hi     = ctl.snap ? snap_edge(hi_raw) : hi_raw;

endmodule

// ----- rtl/core/sqsc_checker.sv -----
// Port-level checks for the sprite quad setup block, bound to its top level.
// Depends on sqsc_pkg and sprite_quad_setup_cull.
module sqsc_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input sqsc_pkg::quad_t   quad
);
  import sqsc_pkg::*;

  // Every taken item produces its quad, through the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##2 done)
    else $error("item taken without a quad two cycles later");

  // No quad appears without an item taken earlier through the input and result registers.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("quad shown without a matching item");

  // A culled quad carries no colour.
  a_cull_color: assert property (@(posedge clk) disable iff (rst)
    done && quad.culled |-> quad.vertex_color == 32'd0)
    else $error("culled quad with nonzero colour");

  // Sizes are never negative, so the edges stay ordered after rounding and saturation.
  a_edge_order: assert property (@(posedge clk) disable iff (rst)
    done |-> (quad.edge_left <= quad.edge_right) && (quad.edge_top <= quad.edge_bottom))
    else $error("quad edges out of order");

endmodule

bind sprite_quad_setup_cull sqsc_checker u_sqsc_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .quad  (quad)
);

// ----- bench/tb_sprite_quad_setup_cull.sv -----
// Self-checking bench for sprite_quad_setup_cull: placement, snapping, saturation,
// viewport cull and colour mix are predicted per item and compared per field.
// Depends on sqsc_pkg and the sprite_quad_setup_cull RTL.
`timescale 1ns / 1ps

class quad_scoreboard;
  localparam int FRAC = sqsc_pkg::FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FRAC;
  localparam longint HALF = longint'(1) << (FRAC - 1);

  logic signed [12:0] shake_x_r;
  logic signed [12:0] shake_y_r;
  logic               mix_on;
  logic [31:0]        mix_rgb;
  logic [11:0]        vleft;
  logic [11:0]        vtop;
  logic [11:0]        vwidth;
  logic [11:0]        vheight;

  sqsc_pkg::quad_t pending[$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned culled_seen;
  int unsigned noted;
  int unsigned reg_writes;

  function new();
    shake_x_r = '0;
    shake_y_r = '0;
    mix_on = 1'b0;
    mix_rgb = '0;
    vleft = '0;
    vtop = '0;
    vwidth = sqsc_pkg::VIEW_WIDTH_RST;
    vheight = sqsc_pkg::VIEW_HEIGHT_RST;
    mismatches = 0;
    checked = 0;
    culled_seen = 0;
    noted = 0;
    reg_writes = 0;
  endfunction

  function void flag(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  function void set_reg(logic [sqsc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
    reg_writes++;
    case (idx)
      sqsc_pkg::REG_SHAKE_X:     shake_x_r = data[12:0];
      sqsc_pkg::REG_SHAKE_Y:     shake_y_r = data[12:0];
      sqsc_pkg::REG_MIX_ENABLE:  mix_on = data[0];
      sqsc_pkg::REG_MIX_COLOR:   mix_rgb = data;
      sqsc_pkg::REG_VIEW_LEFT:   vleft = data[11:0];
      sqsc_pkg::REG_VIEW_TOP:    vtop = data[11:0];
      sqsc_pkg::REG_VIEW_WIDTH:  vwidth = data[11:0];
      sqsc_pkg::REG_VIEW_HEIGHT: vheight = data[11:0];
      default: ;
    endcase
  endfunction

  // Round to the nearest whole pixel, ties to the even pixel, then drop half a pixel.
  function longint snap_to_grid(longint v);
    longint whole;
    longint frac;
    whole = v >>> FRAC;
    frac = v - whole * ONE;
    if (frac > HALF || (frac == HALF && whole[0])) whole = whole + 1;
    return whole * ONE - HALF;
  endfunction

  function void place_axis(logic [1:0] anchor, logic snap, longint pos, longint size,
                           longint shake, output longint lo, output longint hi);
    longint origin;
    longint doubled;
    doubled = 2 * pos - size;
    case (anchor)
      sqsc_pkg::ANCHOR_START: origin = pos;
      sqsc_pkg::ANCHOR_END:   origin = pos - size;
      default: begin
        if (snap) origin = (doubled >>> (FRAC + 1)) * ONE;
        else origin = doubled >>> 1;
      end
    endcase
    lo = origin + shake;
    hi = origin + size + shake;
    if (snap) begin
      lo = snap_to_grid(lo);
      hi = snap_to_grid(hi);
    end
  endfunction

  function logic [15:0] clip16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function logic [31:0] mix_channels(logic [31:0] c, logic [31:0] m);
    logic [31:0] r;
    int unsigned p;
    r = '0;
    for (int ch = 0; ch < 4; ch++) begin
      p = (32'(c[ch*8 +: 8]) * 32'(m[ch*8 +: 8])) >> 7;
      if (p > 255) p = 255;
      r[ch*8 +: 8] = p[7:0];
    end
    return r;
  endfunction

  function sqsc_pkg::quad_t predict_quad(sqsc_pkg::sprite_t s);
    sqsc_pkg::quad_t q;
    longint l, r, t, b;
    longint vl, vt, vr, vb;
    logic [31:0] color;
    place_axis(s.anchor_x, s.snap, longint'($signed(s.pos_x)), longint'($unsigned(s.size_w)),
               longint'(shake_x_r), l, r);
    place_axis(s.anchor_y, s.snap, longint'($signed(s.pos_y)), longint'($unsigned(s.size_h)),
               longint'(shake_y_r), t, b);
    vl = longint'(vleft) * ONE;
    vt = longint'(vtop) * ONE;
    vr = (longint'(vleft) + longint'(vwidth)) * ONE;
    vb = (longint'(vtop) + longint'(vheight)) * ONE;
    // The cull test works on the exact edges, before saturation.
    q.culled = (r < vl) || (b < vt) || (l > vr) || (t > vb);
    color = mix_on ? mix_channels(s.base_color, mix_rgb) : s.base_color;
    q.vertex_color = q.culled ? 32'h0 : color;
    q.edge_left = clip16(l);
    q.edge_right = clip16(r);
    q.edge_top = clip16(t);
    q.edge_bottom = clip16(b);
    return q;
  endfunction

  function void note_sprite(sqsc_pkg::sprite_t s);
    noted++;
    pending.push_back(predict_quad(s));
  endfunction

  function void check_quad(sqsc_pkg::quad_t act);
    sqsc_pkg::quad_t exp_q;
    string diffs;
    if (pending.size() == 0) begin
      flag($sformatf("quad with no sprite waiting: L=%0d R=%0d T=%0d B=%0d color=%08h culled=%0b",
                     $signed(act.edge_left), $signed(act.edge_right), $signed(act.edge_top),
                     $signed(act.edge_bottom), act.vertex_color, act.culled));
      return;
    end
    exp_q = pending.pop_front();
    checked++;
    if (act.culled) culled_seen++;
    diffs = "";
    if (act.edge_left !== exp_q.edge_left) diffs = {diffs, " edge_left"};
    if (act.edge_right !== exp_q.edge_right) diffs = {diffs, " edge_right"};
    if (act.edge_top !== exp_q.edge_top) diffs = {diffs, " edge_top"};
    if (act.edge_bottom !== exp_q.edge_bottom) diffs = {diffs, " edge_bottom"};
    if (act.vertex_color !== exp_q.vertex_color) diffs = {diffs, " vertex_color"};
    if (act.culled !== exp_q.culled) diffs = {diffs, " culled"};
    if (diffs != "") begin
      flag($sformatf({"quad %0d differs in%s\n  expected L=%0d R=%0d T=%0d B=%0d color=%08h ",
                      "culled=%0b\n  actual   L=%0d R=%0d T=%0d B=%0d color=%08h culled=%0b"},
                     checked, diffs,
                     $signed(exp_q.edge_left), $signed(exp_q.edge_right), $signed(exp_q.edge_top),
                     $signed(exp_q.edge_bottom), exp_q.vertex_color, exp_q.culled,
                     $signed(act.edge_left), $signed(act.edge_right), $signed(act.edge_top),
                     $signed(act.edge_bottom), act.vertex_color, act.culled));
    end
  endfunction

  function bit idle();
    return pending.size() == 0;
  endfunction

  function void final_check();
    if (pending.size() != 0) flag($sformatf("%0d quads never arrived", pending.size()));
  endfunction
endclass

module tb_sprite_quad_setup_cull;
  import sqsc_pkg::*;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  sprite_t sprite;
  logic done;
  quad_t quad;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  quad_scoreboard sb = new();
  int unsigned phases_run;

  sprite_quad_setup_cull i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .sprite    (sprite),
    .done      (done),
    .quad      (quad),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Run did not finish in time; %0d quads still outstanding.", sb.pending.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // All sampling happens here, on values as they stood at the clock edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_quad(quad);
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_sprite(sprite);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_sprite(sprite_t s, bit allow_gap);
    int gap;
    start <= 1'b1;
    sprite <= s;
    do @(posedge clk); while (busy);
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops the sender and waits, with a limit, until every quad has come back.
  task automatic wait_drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    @(negedge clk);
    while (!sb.idle() && guard < 1000) begin
      @(negedge clk);
      guard++;
    end
    @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(int phase);
    logic [31:0] sx, sy, me, mc, vl, vt, vw, vh;
    case (phase)
      1: begin
        sx = 32'd4095; sy = 32'd4095; me = 32'd1; mc = 32'hFFFF_FFFF;
        vl = 32'd0; vt = 32'd0; vw = 32'd4095; vh = 32'd4095;
      end
      2: begin
        sx = 32'hFFFF_F000; sy = 32'h0000_1000; me = 32'd1; mc = 32'h80FF_0140;
        vl = 32'd16; vt = 32'd8; vw = 32'd100; vh = 32'd60;
      end
      3: begin
        sx = 32'd0; sy = 32'd0; me = 32'hFFFF_FFFE; mc = 32'd0;
        vl = 32'd4095; vt = 32'd4095; vw = 32'd0; vh = 32'd0;
      end
      default: begin
        sx = $urandom; sy = $urandom; me = $urandom; mc = $urandom;
        vl = $urandom; vt = $urandom; vw = $urandom; vh = $urandom;
        // Keep most random viewports inside the range the positions can reach.
        if ($urandom_range(0, 2) != 0) begin
          vl = $urandom_range(0, 1200);
          vt = $urandom_range(0, 1200);
          vw = $urandom_range(0, 900);
          vh = $urandom_range(0, 900);
        end
      end
    endcase
    write_reg(REG_SHAKE_X, sx);
    write_reg(REG_SHAKE_Y, sy);
    write_reg(REG_MIX_ENABLE, me);
    write_reg(REG_MIX_COLOR, mc);
    write_reg(REG_VIEW_LEFT, vl);
    write_reg(REG_VIEW_TOP, vt);
    write_reg(REG_VIEW_WIDTH, vw);
    write_reg(REG_VIEW_HEIGHT, vh);
    cfg_valid <= 1'b0;
  endtask

  function automatic sprite_t mk(logic snp, logic [1:0] ax, logic [1:0] ay,
                                 logic [15:0] px, logic [15:0] py,
                                 logic [15:0] w, logic [15:0] h, logic [31:0] c);
    sprite_t s;
    s.snap = snp;
    s.anchor_x = ax;
    s.anchor_y = ay;
    s.pos_x = px;
    s.pos_y = py;
    s.size_w = w;
    s.size_h = h;
    s.base_color = c;
    return s;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 16 * 900)) - 16 * 100);
      2: return 16'(int'($urandom_range(0, 900)) * 16 + 8);
      default: return 16'(int'($urandom_range(0, 32)) - 16);
    endcase
  endfunction

  function automatic logic [15:0] rand_size();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 16 * 64));
  endfunction

  function automatic sprite_t rand_sprite();
    return mk(1'($urandom), 2'($urandom), 2'($urandom), rand_coord(), rand_coord(),
              rand_size(), rand_size(), $urandom);
  endfunction

  initial begin
    sprite_t directed[$];
    rst <= 1'b1;
    start <= 1'b0;
    sprite <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    phases_run = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed items under the reset register values: anchors, snapping, ties,
    // saturation, and the cull boundaries on all four sides.
    directed = '{
      mk(0, ANCHOR_CENTER, ANCHOR_CENTER, 1608, 808, 33, 17, 32'hFFFF_FFFF),
      mk(0, ANCHOR_START, ANCHOR_START, 0, 0, 160, 160, 32'h1234_5678),
      mk(0, ANCHOR_END, ANCHOR_END, 800, 640, 160, 80, 32'h89AB_CDEF),
      mk(0, ANCHOR_CENTER_ALT, ANCHOR_CENTER_ALT, 1608, 808, 33, 17, 32'h00FF_00FF),
      mk(1, ANCHOR_CENTER, ANCHOR_CENTER, 16 * 20 + 8, 16 * 21 + 8, 40, 40, 32'hA5A5_A5A5),
      mk(1, ANCHOR_CENTER_ALT, ANCHOR_CENTER_ALT, 16 * 21 + 3, 16 * 30 + 12, 24, 56,
         32'h5A5A_5A5A),
      mk(1, ANCHOR_START, ANCHOR_START, 16 * 20 + 8, 16 * 21 + 8, 64, 64, 32'h0F0F_0F0F),
      mk(1, ANCHOR_END, ANCHOR_END, 16 * 50 + 7, 16 * 50 + 9, 56, 40, 32'hF0F0_F0F0),
      mk(1, ANCHOR_START, ANCHOR_END, 16 * 10 + 9, 16 * 10 + 7, 8, 24, 32'h0000_0001),
      mk(0, ANCHOR_START, ANCHOR_START, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000),
      mk(0, ANCHOR_END, ANCHOR_END, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF),
      mk(1, ANCHOR_START, ANCHOR_START, 16'h7FFF, 16'h8000, 16'hFFFF, 16'hFFFF, 32'hC3C3_C3C3),
      mk(1, ANCHOR_CENTER, ANCHOR_CENTER, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 32'h3C3C_3C3C),
      mk(0, ANCHOR_START, ANCHOR_START, -1600, 160, 160, 160, 32'h1111_1111),
      mk(0, ANCHOR_START, ANCHOR_START, -160, 160, 160, 160, 32'h2222_2222),
      mk(0, ANCHOR_START, ANCHOR_START, 160, -1600, 160, 160, 32'h3333_3333),
      mk(0, ANCHOR_START, ANCHOR_START, 160, -160, 160, 160, 32'h4444_4444),
      mk(0, ANCHOR_START, ANCHOR_START, 16 * 640 + 1, 160, 16, 16, 32'h5555_5555),
      mk(0, ANCHOR_START, ANCHOR_START, 16 * 640, 160, 16, 16, 32'h6666_6666),
      mk(0, ANCHOR_START, ANCHOR_START, 160, 16 * 480 + 1, 16, 16, 32'h7777_7777),
      mk(0, ANCHOR_START, ANCHOR_START, 160, 16 * 480, 16, 16, 32'h8888_8888),
      mk(0, ANCHOR_CENTER, ANCHOR_CENTER, 0, 0, 0, 0, 32'h0000_0000),
      mk(1, ANCHOR_CENTER, ANCHOR_CENTER, -1, -1, 1, 1, 32'hFFFF_FFFF)
    };
    foreach (directed[k]) send_sprite(directed[k], 1'b1);

    // Phase 0 keeps the reset values; every later phase rewrites all registers.
    for (int phase = 0; phase < 8; phase++) begin
      if (phase > 0) begin
        wait_drain();
        configure(phase);
      end
      phases_run++;
      for (int i = 0; i < 185; i++) begin
        send_sprite(rand_sprite(), (i % 100) >= 30);
        if ($urandom_range(0, 99) == 0) wait_drain();
      end
    end

    wait_drain();
    repeat (10) @(posedge clk);
    sb.final_check();
    $display("Ran %0d sprites through %0d register settings with %0d register writes.",
             sb.noted, phases_run, sb.reg_writes);
    $display("Checked %0d quads, %0d of them culled; %0d mismatches.",
             sb.checked, sb.culled_seen, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ----- files.f -----
rtl/core/sqsc_pkg.sv
rtl/core/sqsc_axis.sv
rtl/core/sprite_quad_setup_cull.sv
rtl/core/sqsc_checker.sv
bench/tb_sprite_quad_setup_cull.sv
